>>> hdl/hsv2rgb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Beat types, sector codes and fixed scale constants for the HSV to RGB core.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    typedef struct packed {
        logic [8:0] hue;
        logic [7:0] saturation;
        logic [7:0] value;
    } hsv_pixel_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [23:0] packed_rgb;
    } rgb_pixel_t;

    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } sector_t;

    localparam int SECTOR_DEG  = 60;
    localparam int SECTORS     = 6;
    localparam int MAX_SECTOR  = 511 / SECTOR_DEG;
    localparam int FULL_SCALE  = 255;
    localparam int FINE_SCALE  = 15300;

    // floor(y / 3825) = (y * RECIP_3825) >> RECIP_SHIFT for y < 2**20
    localparam logic [20:0] RECIP_3825  = 21'd1122868;
    localparam int          RECIP_SHIFT = 32;

endpackage
`default_nettype wire

>>> hdl/hsv_to_rgb_convert_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert_core
// Six-stage pipelined HSV to RGB pixel converter with valid/ready channels.
// Throughput: one pixel per cycle; all stages advance together on one enable.
// A stall at the output holds every stage in place.
// Reset (aresetn low, synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert_core
    import hsv2rgb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  hsv_pixel_t      s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output rgb_pixel_t      m_data
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] valid_reg, valid_next;
    logic              advance;

    assign advance = !valid_reg[STAGES-1] || m_ready;
    assign s_ready = advance;
    assign m_valid = valid_reg[STAGES-1];

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = {valid_reg[STAGES-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // stage 1: sector and remainder
    logic [3:0] sec_raw;
    logic [8:0] sec_base;
    logic [3:0] sec_wrap;

    always_comb begin
        sec_raw  = '0;
        sec_base = '0;
        for (int k = 1; k <= MAX_SECTOR; k++) begin
            if (s_data.hue >= 9'(k * SECTOR_DEG)) begin
                sec_raw  = 4'(k);
                sec_base = 9'(k * SECTOR_DEG);
            end
        end
        sec_wrap = (sec_raw >= 4'(SECTORS)) ? sec_raw - 4'(SECTORS) : sec_raw;
    end

    sector_t    s1_sector_reg;
    logic [5:0] s1_hf_reg;
    logic [7:0] s1_sat_reg;
    logic [7:0] s1_val_reg;

    // stage 2: products
    sector_t     s2_sector_reg;
    logic [7:0]  s2_val_reg;
    logic [15:0] s2_pprod_reg;
    logic [13:0] s2_qsub_reg;
    logic [13:0] s2_tsub_reg;

    // stage 3: p and fine numerators
    sector_t     s3_sector_reg;
    logic [7:0]  s3_val_reg;
    logic [7:0]  s3_p_reg;
    logic [13:0] s3_qn_reg;
    logic [13:0] s3_tn_reg;

    // stage 4: scaled numerators
    sector_t     s4_sector_reg;
    logic [7:0]  s4_val_reg;
    logic [7:0]  s4_p_reg;
    logic [21:0] s4_qprod_reg;
    logic [21:0] s4_tprod_reg;

    // stage 5: reciprocal products
    sector_t     s5_sector_reg;
    logic [7:0]  s5_val_reg;
    logic [7:0]  s5_p_reg;
    logic [40:0] s5_qmul_reg;
    logic [40:0] s5_tmul_reg;

    // stage 6: output
    rgb_pixel_t  m_data_reg, m_data_next;

    logic [7:0]  sat_inv;
    logic [5:0]  hf_inv;
    logic [16:0] p_sum;
    logic [7:0]  q_lvl;
    logic [7:0]  t_lvl;

    assign sat_inv = 8'(FULL_SCALE) - s1_sat_reg;
    assign hf_inv  = 6'(SECTOR_DEG) - s1_hf_reg;
    assign p_sum   = {1'b0, s2_pprod_reg} + 17'(s2_pprod_reg[15:8]) + 17'd1;
    assign q_lvl   = s5_qmul_reg[RECIP_SHIFT +: 8];
    assign t_lvl   = s5_tmul_reg[RECIP_SHIFT +: 8];

    always_comb begin
        m_data_next = '0;
        case (s5_sector_reg)
            SEC_R_TO_Y: begin
                m_data_next.red   = s5_val_reg;
                m_data_next.green = t_lvl;
                m_data_next.blue  = s5_p_reg;
            end
            SEC_Y_TO_G: begin
                m_data_next.red   = q_lvl;
                m_data_next.green = s5_val_reg;
                m_data_next.blue  = s5_p_reg;
            end
            SEC_G_TO_C: begin
                m_data_next.red   = s5_p_reg;
                m_data_next.green = s5_val_reg;
                m_data_next.blue  = t_lvl;
            end
            SEC_C_TO_B: begin
                m_data_next.red   = s5_p_reg;
                m_data_next.green = q_lvl;
                m_data_next.blue  = s5_val_reg;
            end
            SEC_B_TO_M: begin
                m_data_next.red   = t_lvl;
                m_data_next.green = s5_p_reg;
                m_data_next.blue  = s5_val_reg;
            end
            default: begin
                m_data_next.red   = s5_val_reg;
                m_data_next.green = s5_p_reg;
                m_data_next.blue  = q_lvl;
            end
        endcase
        m_data_next.packed_rgb = {m_data_next.red, m_data_next.green, m_data_next.blue};
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_sector_reg <= sector_t'(sec_wrap[2:0]);
            s1_hf_reg     <= 6'(s_data.hue - sec_base);
            s1_sat_reg    <= s_data.saturation;
            s1_val_reg    <= s_data.value;

            s2_sector_reg <= s1_sector_reg;
            s2_val_reg    <= s1_val_reg;
            s2_pprod_reg  <= 16'(s1_val_reg) * 16'(sat_inv);
            s2_qsub_reg   <= 14'(s1_sat_reg) * 14'(s1_hf_reg);
            s2_tsub_reg   <= 14'(s1_sat_reg) * 14'(hf_inv);

            s3_sector_reg <= s2_sector_reg;
            s3_val_reg    <= s2_val_reg;
            s3_p_reg      <= p_sum[15:8];
            s3_qn_reg     <= 14'(FINE_SCALE) - s2_qsub_reg;
            s3_tn_reg     <= 14'(FINE_SCALE) - s2_tsub_reg;

            s4_sector_reg <= s3_sector_reg;
            s4_val_reg    <= s3_val_reg;
            s4_p_reg      <= s3_p_reg;
            s4_qprod_reg  <= 22'(s3_val_reg) * 22'(s3_qn_reg);
            s4_tprod_reg  <= 22'(s3_val_reg) * 22'(s3_tn_reg);

            s5_sector_reg <= s4_sector_reg;
            s5_val_reg    <= s4_val_reg;
            s5_p_reg      <= s4_p_reg;
            s5_qmul_reg   <= 41'(s4_qprod_reg[21:2]) * 41'(RECIP_3825);
            s5_tmul_reg   <= 41'(s4_tprod_reg[21:2]) * 41'(RECIP_3825);

            m_data_reg    <= m_data_next;
        end
    end

    assign m_data = m_data_reg;

    a_reset_empty : assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("output valid after reset");

    a_stage_move : assert property (@(posedge aclk) disable iff (!aresetn)
        advance && valid_reg[0] |=> valid_reg[1])
        else $error("beat lost between stages");

    a_p_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[2] |-> s3_p_reg <= s3_val_reg)
        else $error("p level above value");

    a_fine_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[4] |-> (q_lvl <= s5_val_reg) && (t_lvl <= s5_val_reg)
                         && (s5_qmul_reg[40] == 1'b0))
        else $error("q or t level above value");

endmodule
`default_nettype wire

>>> sim/hsv_to_rgb_convert_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert_core_tb
// Drives HSV pixel beats through the converter with random gaps on the input
// and random stalls on the output. Each accepted pixel is converted by a
// behavioral integer model. The result is queued, and every output beat is
// compared against the oldest queued result, field by field. The stimulus
// covers the sector edges, hue values past 359, and the extremes of
// saturation and value, followed by random pixels.
// ----------------------------------------------------------------------------
import hsv2rgb_pkg::*;

class rgb_scoreboard;
    rgb_pixel_t expected_rgb[$];
    int         failures;

    function new();
        failures = 0;
    endfunction

    function int pending();
        return expected_rgb.size();
    endfunction

    function rgb_pixel_t convert(hsv_pixel_t px);
        int unsigned h;
        int unsigned s;
        int unsigned v;
        int unsigned hf;
        int unsigned p;
        int unsigned q;
        int unsigned t;
        sector_t     sec;
        rgb_pixel_t  res;
        h   = px.hue;
        s   = px.saturation;
        v   = px.value;
        sec = sector_t'((h / SECTOR_DEG) % SECTORS);
        hf  = h % SECTOR_DEG;
        p   = v * (FULL_SCALE - s) / FULL_SCALE;
        q   = v * (FINE_SCALE - s * hf) / FINE_SCALE;
        t   = v * (FINE_SCALE - s * (SECTOR_DEG - hf)) / FINE_SCALE;
        case (sec)
            SEC_R_TO_Y: begin
                res.red = 8'(v); res.green = 8'(t); res.blue = 8'(p);
            end
            SEC_Y_TO_G: begin
                res.red = 8'(q); res.green = 8'(v); res.blue = 8'(p);
            end
            SEC_G_TO_C: begin
                res.red = 8'(p); res.green = 8'(v); res.blue = 8'(t);
            end
            SEC_C_TO_B: begin
                res.red = 8'(p); res.green = 8'(q); res.blue = 8'(v);
            end
            SEC_B_TO_M: begin
                res.red = 8'(t); res.green = 8'(p); res.blue = 8'(v);
            end
            default: begin
                res.red = 8'(v); res.green = 8'(p); res.blue = 8'(q);
            end
        endcase
        res.packed_rgb = {res.red, res.green, res.blue};
        return res;
    endfunction

    function void note_pixel(hsv_pixel_t px);
        expected_rgb.push_back(convert(px));
    endfunction

    function void check_rgb(rgb_pixel_t got);
        rgb_pixel_t want;
        if (expected_rgb.size() == 0) begin
            $error("result beat with nothing expected: %h", got);
            failures++;
            return;
        end
        want = expected_rgb.pop_front();
        if (got.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            failures++;
        end
        if (got.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            failures++;
        end
        if (got.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            failures++;
        end
        if (got.packed_rgb !== want.packed_rgb) begin
            $error("packed_rgb: expected %h, got %h", want.packed_rgb, got.packed_rgb);
            failures++;
        end
    endfunction
endclass

module hsv_to_rgb_convert_core_tb;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int RANDOM_PIXELS   = 1900;
    localparam int DRAIN_CYCLES    = 12;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    hsv_pixel_t s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    rgb_pixel_t m_data;

    bit            no_gaps      = 1'b0;
    int            stall_cycles = 0;
    rgb_scoreboard sb           = new();

    hsv_to_rgb_convert_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'd0;
        end else if (r == 1) begin
            return 8'd255;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic hsv_pixel_t pick_pixel();
        hsv_pixel_t px;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            px.hue = 9'($urandom_range(0, 359));
        end else if (r < 90) begin
            px.hue = 9'($urandom_range(0, 5) * SECTOR_DEG + (r[0] ? SECTOR_DEG - 1 : 0));
        end else begin
            px.hue = 9'($urandom_range(360, 511));
        end
        px.saturation = pick_level();
        px.value      = pick_level();
        return px;
    endfunction

    task automatic send_pixel(input hsv_pixel_t px);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_rgb(m_data);
        end
        if (aresetn && s_valid && s_ready) begin
            sb.note_pixel(s_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_CYCLES) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_pixel({9'd0,   8'd0,   8'd0});
        send_pixel({9'd0,   8'd255, 8'd255});
        send_pixel({9'd59,  8'd255, 8'd255});
        send_pixel({9'd60,  8'd255, 8'd255});
        send_pixel({9'd119, 8'd255, 8'd255});
        send_pixel({9'd120, 8'd255, 8'd255});
        send_pixel({9'd179, 8'd255, 8'd255});
        send_pixel({9'd180, 8'd255, 8'd255});
        send_pixel({9'd239, 8'd255, 8'd255});
        send_pixel({9'd240, 8'd255, 8'd255});
        send_pixel({9'd299, 8'd255, 8'd255});
        send_pixel({9'd300, 8'd255, 8'd255});
        send_pixel({9'd359, 8'd255, 8'd255});
        send_pixel({9'd360, 8'd255, 8'd255});
        send_pixel({9'd420, 8'd255, 8'd255});
        send_pixel({9'd480, 8'd200, 8'd255});
        send_pixel({9'd511, 8'd255, 8'd255});
        send_pixel({9'd200, 8'd0,   8'd173});
        send_pixel({9'd30,  8'd128, 8'd0});
        send_pixel({9'd90,  8'd1,   8'd254});
        send_pixel({9'd330, 8'd127, 8'd128});
        send_pixel({9'd45,  8'd254, 8'd1});
        send_pixel({9'd256, 8'd170, 8'd85});

        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            no_gaps = ((i / 250) % 3) == 1;
            if (i == RANDOM_PIXELS / 2) begin
                hold_until_drained();
            end
            send_pixel(pick_pixel());
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
